### src/sirt_pkg.sv
// shared types, constants and tables for the signed integer to radix text block
// no dependencies; imported by sirt_ctrl, sirt_datapath and the top level
package sirt_pkg;

   // alphabet size limit; storage always holds 16 bytes
   localparam int MAX_ALPHABET_LEN = 16;
   localparam int ALPHA_BYTES      = 16;
   localparam int ALPHA_CAP        = (MAX_ALPHABET_LEN > ALPHA_BYTES) ? ALPHA_BYTES
                                                                     : MAX_ALPHABET_LEN;

   // port and datapath widths
   localparam int VALUE_WIDTH     = 32;
   localparam int CHAR_WIDTH      = 8;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int RADIX_WIDTH     = 5;
   localparam int DIGIT_WIDTH     = 4;
   localparam int DIGIT_DEPTH     = 32;
   localparam int DIGIT_IDX_WIDTH = 5;
   localparam int COUNT_WIDTH     = 6;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ALPHA_LOW  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ALPHA_HIGH = 2'd1;

   // character codes
   localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CHAR_WS_LO = 8'd9;
   localparam logic [CHAR_WIDTH-1:0] CHAR_WS_HI = 8'd13;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic mul;
      logic fix;
      logic emit_sign;
      logic emit_digit;
   } sirt_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic radix_zero;
      logic mag_zero;
      logic count_zero;
      logic count_one;
      logic neg;
      logic out_free;
   } sirt_status_type;

   // floor(2^32 / radix) for the reciprocal divide
   function automatic logic [VALUE_WIDTH-1:0] recip_lookup(input logic [RADIX_WIDTH-1:0] radix);
      logic [VALUE_WIDTH-1:0] r;
      case (radix)
         5'd2:    r = 32'd2147483648;
         5'd3:    r = 32'd1431655765;
         5'd4:    r = 32'd1073741824;
         5'd5:    r = 32'd858993459;
         5'd6:    r = 32'd715827882;
         5'd7:    r = 32'd613566756;
         5'd8:    r = 32'd536870912;
         5'd9:    r = 32'd477218588;
         5'd10:   r = 32'd429496729;
         5'd11:   r = 32'd390451572;
         5'd12:   r = 32'd357913941;
         5'd13:   r = 32'd330382099;
         5'd14:   r = 32'd306783378;
         5'd15:   r = 32'd286331153;
         5'd16:   r = 32'd268435456;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

### src/sirt_datapath.sv
// datapath: alphabet registers and check, reciprocal divider, digit stack, output register
// depends on sirt_pkg; driven by commands from sirt_ctrl
module sirt_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_valid,
   input  logic [sirt_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [sirt_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata,
   input  logic signed [sirt_pkg::VALUE_WIDTH-1:0] req_value,
   input  logic                                    rsp_stall,
   input  sirt_pkg::sirt_cmd_type                  cmd,
   output sirt_pkg::sirt_status_type               status,
   output logic                                    rsp_valid,
   output logic [sirt_pkg::CHAR_WIDTH-1:0]         rsp_out_char,
   output logic                                    rsp_is_last
);
   import sirt_pkg::*;

   logic [CSR_DATA_WIDTH-1:0]  alpha_low_ff;
   logic [CSR_DATA_WIDTH-1:0]  alpha_high_ff;
   logic [CHAR_WIDTH-1:0]      alpha_chr [ALPHA_BYTES];
   logic [RADIX_WIDTH-1:0]     chk_radix;

   logic                       neg_ff;
   logic [VALUE_WIDTH-1:0]     mag_ff;
   logic [VALUE_WIDTH-1:0]     mag_in;
   logic [RADIX_WIDTH-1:0]     radix_ff;
   logic [VALUE_WIDTH-1:0]     recip_ff;
   logic [VALUE_WIDTH-1:0]     prod_hi_ff;
   logic [2*VALUE_WIDTH-1:0]   prod_full;
   logic [VALUE_WIDTH+RADIX_WIDTH-1:0] fix_mul;
   logic [VALUE_WIDTH-1:0]     radix_ext;
   logic [VALUE_WIDTH-1:0]     rem_raw;
   logic [VALUE_WIDTH-1:0]     rem_fix;
   logic [VALUE_WIDTH-1:0]     quot_fix;

   logic [DIGIT_WIDTH-1:0]     digit_ff [DIGIT_DEPTH];
   logic [COUNT_WIDTH-1:0]     count_ff;
   logic [COUNT_WIDTH-1:0]     count_in;
   logic [COUNT_WIDTH-1:0]     count_dec;
   logic [DIGIT_IDX_WIDTH-1:0] rd_idx;

   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [CHAR_WIDTH-1:0]      rsp_char_ff;
   logic                       rsp_last_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_low_ff  <= '0;
         alpha_high_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ALPHA_LOW:  alpha_low_ff  <= csr_wdata;
            CSR_ALPHA_HIGH: alpha_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // split the registers into alphabet bytes
   always_comb begin
      for (int i = 0; i < ALPHA_BYTES / 2; i++) begin
         alpha_chr[i]                   = alpha_low_ff[CHAR_WIDTH*i +: CHAR_WIDTH];
         alpha_chr[i + ALPHA_BYTES / 2] = alpha_high_ff[CHAR_WIDTH*i +: CHAR_WIDTH];
      end
   end

   // alphabet length and validity; radix is zero when the alphabet is unusable
   always_comb begin
      logic                   run;
      logic [ALPHA_BYTES-1:0] in_alpha;
      logic [RADIX_WIDTH-1:0] len;
      logic                   bad;
      logic                   dup;
      run = 1'b1;
      len = '0;
      bad = 1'b0;
      dup = 1'b0;
      for (int i = 0; i < ALPHA_BYTES; i++) begin
         run         = run & (alpha_chr[i] != '0) & (i < ALPHA_CAP);
         in_alpha[i] = run;
         len         = len + RADIX_WIDTH'(run);
      end
      for (int i = 0; i < ALPHA_BYTES; i++) begin
         if (in_alpha[i] && (alpha_chr[i] == CHAR_PLUS || alpha_chr[i] == CHAR_MINUS ||
                             alpha_chr[i] == CHAR_SPACE ||
                             (alpha_chr[i] >= CHAR_WS_LO && alpha_chr[i] <= CHAR_WS_HI)))
            bad = 1'b1;
      end
      for (int i = 0; i < ALPHA_BYTES; i++) begin
         for (int j = i + 1; j < ALPHA_BYTES; j++) begin
            if (in_alpha[j] && alpha_chr[i] == alpha_chr[j])
               dup = 1'b1;
         end
      end
      chk_radix = (len >= RADIX_WIDTH'(2) && !bad && !dup) ? len : '0;
   end

   // reciprocal product and quotient correction
   assign prod_full = mag_ff * recip_ff;
   assign radix_ext = {{(VALUE_WIDTH-RADIX_WIDTH){1'b0}}, radix_ff};
   assign fix_mul   = {{RADIX_WIDTH{1'b0}}, prod_hi_ff} *
                      {{VALUE_WIDTH{1'b0}}, radix_ff};
   assign rem_raw   = mag_ff - fix_mul[VALUE_WIDTH-1:0];

   always_comb begin
      if (rem_raw >= radix_ext) begin
         rem_fix  = rem_raw - radix_ext;
         quot_fix = prod_hi_ff + VALUE_WIDTH'(1);
      end else begin
         rem_fix  = rem_raw;
         quot_fix = prod_hi_ff;
      end
   end

   // magnitude and digit count next values
   assign count_dec = count_ff - COUNT_WIDTH'(1);
   assign rd_idx    = count_dec[DIGIT_IDX_WIDTH-1:0];

   always_comb begin
      mag_in   = mag_ff;
      count_in = count_ff;
      if (cmd.load) begin
         mag_in   = req_value[VALUE_WIDTH-1] ? VALUE_WIDTH'(-req_value)
                                             : VALUE_WIDTH'(req_value);
         count_in = '0;
      end else if (cmd.fix) begin
         mag_in   = quot_fix;
         count_in = count_ff + COUNT_WIDTH'(1);
      end else if (cmd.emit_digit) begin
         count_in = count_dec;
      end
   end

   // digit count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // operand, product and digit stack registers
   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      if (cmd.load) begin
         neg_ff   <= req_value[VALUE_WIDTH-1];
         radix_ff <= chk_radix;
         recip_ff <= recip_lookup(chk_radix);
      end
      if (cmd.mul) begin
         prod_hi_ff <= prod_full[2*VALUE_WIDTH-1:VALUE_WIDTH];
      end
      if (cmd.fix) begin
         digit_ff[count_ff[DIGIT_IDX_WIDTH-1:0]] <= rem_fix[DIGIT_WIDTH-1:0];
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.emit_sign || cmd.emit_digit)
         rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_sign) begin
         rsp_char_ff <= CHAR_MINUS;
         rsp_last_ff <= 1'b0;
      end else if (cmd.emit_digit) begin
         rsp_char_ff <= alpha_chr[digit_ff[rd_idx]];
         rsp_last_ff <= (count_ff == COUNT_WIDTH'(1));
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_is_last  = rsp_last_ff;

   // status to the controller
   assign status.radix_zero = (radix_ff == '0);
   assign status.mag_zero   = (mag_ff == '0);
   assign status.count_zero = (count_ff == '0);
   assign status.count_one  = (count_ff == COUNT_WIDTH'(1));
   assign status.neg        = neg_ff;
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

endmodule

### src/sirt_ctrl.sv
// controller state machine: sequences accept, digit divide loop and character emission
// depends on sirt_pkg; drives commands into sirt_datapath
module sirt_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  sirt_pkg::sirt_status_type status,
   output sirt_pkg::sirt_cmd_type    cmd
);
   import sirt_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_START = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_FIX   = 3'd3;
   localparam logic [2:0] ST_SIGN  = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = status.radix_zero ? ST_IDLE : ST_MUL;
         end
         ST_MUL: begin
            if (!status.count_zero && status.mag_zero) begin
               state_in = ST_SIGN;
            end else begin
               cmd.mul  = 1'b1;
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            cmd.fix  = 1'b1;
            state_in = ST_MUL;
         end
         ST_SIGN: begin
            if (!status.neg) begin
               state_in = ST_EMIT;
            end else if (status.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               if (status.count_one)
                  state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

### src/signed_integer_to_radix_text.sv
// Signed integer to radix text converter.
// Request channel (req_valid/req_stall/req_value) takes one signed 32-bit value per
// transaction. Response channel (rsp_valid/rsp_stall) returns one character per
// transaction: an optional '-' then the digits most significant first, rsp_is_last
// set on the final character. csr_* writes the two alphabet registers (index 0:
// bytes 0-7, index 1: bytes 8-15); csr_ready is always high.
// The alphabet ends at the first zero byte; an alphabet shorter than two characters,
// with a repeated character, or holding '+', '-', space or 9..13 yields no output.
// Sequence: one value at a time. The value is accepted and the alphabet checked, then
// each digit passes through the reciprocal multiply and the correction unit, a further
// step detects the end of the digits, the sign step loads the '-' once the output is
// free or passes by when the value is positive, then one digit is emitted per cycle
// while the output is free; a value has up to 32 digits for radix 2, 10 for radix 10.
// A rejected alphabet returns to idle after the check. The next value is taken once the
// last character is loaded into the output register, while that character still waits.
// Reset clears the alphabet to empty, the controller to idle and the output valid.
// A stalled response holds its character and holds the controller when it has one to load.
// No clearing pass is needed after reset.
module signed_integer_to_radix_text (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [sirt_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [sirt_pkg::CHAR_WIDTH-1:0]         rsp_out_char,
   output logic                                    rsp_is_last,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [sirt_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [sirt_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);
   import sirt_pkg::*;

   sirt_cmd_type    cmd;
   sirt_status_type status;

   assign csr_ready = 1'b1;

   // sequencing
   sirt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // divide, digit stack and output
   sirt_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_value    (req_value),
      .rsp_stall    (rsp_stall),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_out_char (rsp_out_char),
      .rsp_is_last  (rsp_is_last)
   );

`ifndef SYNTH
   // an accepted value keeps the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block not busy after accepting a value");

   // characters are only loaded into a free output slot
   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_sign || cmd.emit_digit) |-> status.out_free)
      else $error("character loaded over a pending response");

   // the final digit returns the controller to idle
   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_digit && status.count_one) |=> !req_stall)
      else $error("controller not idle after the final character");
`endif

endmodule
